@@ design/mtkc_pkg.sv @@
// shared types, constants and keyword tables for the manifest tag keyword checker
package mtkc_pkg;

    localparam int NUM_DEVICES = 3;
    localparam int KW_COUNT    = 3;
    localparam int KW_MAX_LEN  = 16;
    localparam int IDX_W       = 4;
    localparam int DEV_W       = 2;
    localparam int MASK_W      = 3;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [IDX_W-1:0] IDX_MAX  = 4'd15;
    localparam logic [DEV_W-1:0] DEV_NONE = 2'd3;

    localparam logic [DEV_W-1:0] DEV_ENCODER    = 2'd0;
    localparam logic [DEV_W-1:0] DEV_SERIAL     = 2'd1;
    localparam logic [DEV_W-1:0] DEV_ULTRASONIC = 2'd2;

    localparam logic [MASK_W-1:0] PRESENT_MASK_RESET = 3'd7;

    // register index is the word address
    localparam logic REG_PRESENT_MASK = 1'b0;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    // keyword text as ascii, first character in the top byte, zero padded
    localparam logic [0:KW_MAX_LEN-1][7:0] KW_ENCODER    =
        128'h5553455F454E434F4445520000000000;
    localparam logic [0:KW_MAX_LEN-1][7:0] KW_SERIAL     =
        128'h5553455F53455249414C000000000000;
    localparam logic [0:KW_MAX_LEN-1][7:0] KW_ULTRASONIC =
        128'h5553455F554C545241534F4E49430000;

    typedef enum logic [2:0] {
        PH_OPEN  = 3'd0,
        PH_TAG   = 3'd1,
        PH_BODY  = 3'd2,
        PH_SLASH = 3'd3,
        PH_CNAME = 3'd4,
        PH_CGT   = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        ST_RUN    = 2'd0,
        ST_ACCEPT = 2'd1,
        ST_REJECT = 2'd2
    } verdict_t;

    typedef struct packed {
        logic       op;
        logic [7:0] char_byte;
    } item_t;

    typedef struct packed {
        verdict_t         status;
        logic [DEV_W-1:0] last_device;
    } result_t;

    typedef struct packed {
        verdict_t verdict;
        phase_t   phase;
    } scan_stat_t;

    function automatic logic [7:0] tag_char(input logic [IDX_W-1:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = 8'h70; // p
            4'd1:    c = 8'h65; // e
            4'd2:    c = 8'h72; // r
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] kw_char(input logic [DEV_W-1:0] dev,
                                           input logic [IDX_W-1:0] pos);
        logic [7:0] c;
        case (dev)
            DEV_ENCODER:    c = KW_ENCODER[pos];
            DEV_SERIAL:     c = KW_SERIAL[pos];
            DEV_ULTRASONIC: c = KW_ULTRASONIC[pos];
            default:        c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [IDX_W:0] kw_len(input logic [DEV_W-1:0] dev);
        logic [IDX_W:0] n;
        case (dev)
            DEV_ENCODER:    n = 5'd11;
            DEV_SERIAL:     n = 5'd10;
            DEV_ULTRASONIC: n = 5'd14;
            default:        n = 5'd0;
        endcase
        return n;
    endfunction

endpackage

@@ design/mtkc_in_buf.sv @@
// input register holding one accepted manifest item
module mtkc_in_buf (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            op,
    input  logic [7:0]      char_byte,
    output logic            item_valid,
    output mtkc_pkg::item_t item,
    input  logic            pop
);
    import mtkc_pkg::*;

    logic  item_valid_reg;
    logic  item_valid_next;
    item_t item_reg;

    assign in_ready = !item_valid_reg || pop;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (in_ready)
        begin
            item_valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= '{op: op, char_byte: char_byte};
        end
    end

    assign item_valid = item_valid_reg;
    assign item       = item_reg;

endmodule

@@ design/mtkc_scan.sv @@
// parser state and next-state logic for one manifest item
module mtkc_scan (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         advance,
    input  mtkc_pkg::item_t              item,
    input  logic [mtkc_pkg::MASK_W-1:0]  present_mask,
    output mtkc_pkg::result_t            result,
    output mtkc_pkg::scan_stat_t         stat
);
    import mtkc_pkg::*;

    phase_t              phase_reg,        phase_next;
    logic [IDX_W-1:0]    char_index_reg,   char_index_next;
    logic                tag_alive_reg,    tag_alive_next;
    logic                tag_seen_reg,     tag_seen_next;
    logic [KW_COUNT-1:0] device_alive_reg, device_alive_next;
    logic [DEV_W-1:0]    device_pick_reg,  device_pick_next;
    verdict_t            verdict_reg,      verdict_next;

    logic [IDX_W-1:0] index_bumped;
    logic [7:0]       c;
    logic             pick_absent;

    assign c            = item.char_byte;
    assign index_bumped = (char_index_reg == IDX_MAX) ? char_index_reg
                                                       : char_index_reg + 4'd1;
    // capability bit of the matched device is clear
    assign pick_absent  = (device_pick_reg != DEV_NONE)
                       && !present_mask[device_pick_reg];

    // next state
    always_comb
    begin
        phase_next        = phase_reg;
        char_index_next   = char_index_reg;
        tag_alive_next    = tag_alive_reg;
        tag_seen_next     = tag_seen_reg;
        device_alive_next = device_alive_reg;
        device_pick_next  = device_pick_reg;
        verdict_next      = verdict_reg;
        if (verdict_reg == ST_RUN)
        begin
            if (item.op == OP_END)
            begin
                verdict_next = (phase_reg == PH_OPEN) ? ST_ACCEPT : ST_REJECT;
            end
            else
            begin
                case (phase_reg)
                    PH_OPEN:
                    begin
                        if (c != CH_LT)
                        begin
                            verdict_next = ST_REJECT;
                        end
                        else
                        begin
                            char_index_next = '0;
                            tag_alive_next  = 1'b1;
                            tag_seen_next   = 1'b0;
                            phase_next      = PH_TAG;
                        end
                    end
                    PH_TAG:
                    begin
                        if (c == CH_GT)
                        begin
                            if (!tag_seen_reg)
                            begin
                                verdict_next = ST_REJECT;
                            end
                            else
                            begin
                                char_index_next   = '0;
                                device_alive_next = '1;
                                device_pick_next  = DEV_NONE;
                                phase_next        = PH_BODY;
                            end
                        end
                        else
                        begin
                            if (tag_alive_reg)
                            begin
                                if (char_index_reg > 4'd2 || c != tag_char(char_index_reg))
                                begin
                                    tag_alive_next = 1'b0;
                                end
                                else if (char_index_reg == 4'd2)
                                begin
                                    tag_alive_next = 1'b0;
                                    tag_seen_next  = 1'b1;
                                end
                            end
                            char_index_next = index_bumped;
                        end
                    end
                    PH_BODY:
                    begin
                        if (c == CH_LT)
                        begin
                            if (pick_absent)
                            begin
                                verdict_next = ST_REJECT;
                            end
                            else
                            begin
                                phase_next = PH_SLASH;
                            end
                        end
                        else
                        begin
                            // keyword candidates drop out at their first mismatch or once fully matched
                            for (int i = 0; i < KW_COUNT; i++)
                            begin
                                if (i < NUM_DEVICES && device_alive_reg[i])
                                begin
                                    if ({1'b0, char_index_reg} >= kw_len(DEV_W'(i))
                                        || c != kw_char(DEV_W'(i), char_index_reg))
                                    begin
                                        device_alive_next[i] = 1'b0;
                                    end
                                    else if ({1'b0, char_index_reg} + 5'd1
                                             == kw_len(DEV_W'(i)))
                                    begin
                                        device_alive_next[i] = 1'b0;
                                        device_pick_next     = DEV_W'(i);
                                    end
                                end
                            end
                            char_index_next = index_bumped;
                        end
                    end
                    PH_SLASH:
                    begin
                        if (c != CH_SLASH)
                        begin
                            verdict_next = ST_REJECT;
                        end
                        else
                        begin
                            char_index_next = '0;
                            phase_next      = PH_CNAME;
                        end
                    end
                    PH_CNAME:
                    begin
                        if (char_index_reg > 4'd2 || c != tag_char(char_index_reg))
                        begin
                            verdict_next = ST_REJECT;
                        end
                        else
                        begin
                            if (char_index_reg == 4'd2)
                            begin
                                phase_next = PH_CGT;
                            end
                            char_index_next = index_bumped;
                        end
                    end
                    PH_CGT:
                    begin
                        if (c != CH_GT)
                        begin
                            verdict_next = ST_REJECT;
                        end
                        else
                        begin
                            phase_next = PH_OPEN;
                        end
                    end
                    default:
                    begin
                        verdict_next = ST_REJECT;
                    end
                endcase
            end
        end
    end

    // outputs
    always_comb
    begin
        result.status      = verdict_next;
        result.last_device = device_pick_next;
        stat.verdict       = verdict_reg;
        stat.phase         = phase_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_OPEN;
            char_index_reg   <= '0;
            tag_alive_reg    <= 1'b1;
            tag_seen_reg     <= 1'b0;
            device_alive_reg <= '1;
            device_pick_reg  <= DEV_NONE;
            verdict_reg      <= ST_RUN;
        end
        else if (advance)
        begin
            phase_reg        <= phase_next;
            char_index_reg   <= char_index_next;
            tag_alive_reg    <= tag_alive_next;
            tag_seen_reg     <= tag_seen_next;
            device_alive_reg <= device_alive_next;
            device_pick_reg  <= device_pick_next;
            verdict_reg      <= verdict_next;
        end
    end

endmodule

@@ design/mtkc_out_reg.sv @@
// result register on the output channel
module mtkc_out_reg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  mtkc_pkg::result_t           result,
    output logic                        room,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [1:0]                  status,
    output logic [mtkc_pkg::DEV_W-1:0]  last_device
);
    import mtkc_pkg::*;

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t result_reg;

    assign room = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (room)
        begin
            out_valid_next = push;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && room)
        begin
            result_reg <= result;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = result_reg.status;
    assign last_device = result_reg.last_device;

endmodule

@@ design/mtkc_regs.sv @@
// configuration register file behind the apb port
module mtkc_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mtkc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [mtkc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [mtkc_pkg::APB_DATA_W-1:0]  prdata,
    output logic [mtkc_pkg::MASK_W-1:0]      present_mask
);
    import mtkc_pkg::*;

    logic [MASK_W-1:0] present_mask_reg;
    logic [MASK_W-1:0] present_mask_next;
    logic              reg_idx;
    logic              wr_en;

    assign reg_idx = paddr[APB_ADDR_W-1];
    assign wr_en   = psel && penable && pwrite;

    always_comb
    begin
        present_mask_next = present_mask_reg;
        if (wr_en && reg_idx == REG_PRESENT_MASK)
        begin
            present_mask_next = pwdata[MASK_W-1:0];
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_PRESENT_MASK: prdata = {{(APB_DATA_W-MASK_W){1'b0}}, present_mask_reg};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_mask_reg <= PRESENT_MASK_RESET;
        end
        else
        begin
            present_mask_reg <= present_mask_next;
        end
    end

    assign present_mask = present_mask_reg;

endmodule

@@ design/manifest_tag_keyword_checker_top.sv @@
// top level of the manifest tag keyword checker
// Checks a manifest of <per>NAME</per> records one byte per transfer, with no
// buffer: each input transfer (a byte, or the end-of-manifest mark) gives exactly
// one result transfer carrying the running status (running, accepted, rejected)
// and the device matched in the latest record body. The block takes one item
// per clock cycle while the result channel is not stalled; a result passes
// through the input register, then the result register, before it is offered.
// While a result waits, the input register can still take one more item if it
// is empty, and then the input stalls until the result is taken.
// present_mask sits at byte address 0 of the apb port; it must be written only
// while no transfer is in flight. A rejection or acceptance holds until reset.
module manifest_tag_keyword_checker_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             op,
    input  logic [7:0]                       char_byte,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [1:0]                       status,
    output logic [1:0]                       last_device,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mtkc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [mtkc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [mtkc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import mtkc_pkg::*;

    logic              item_valid;
    item_t             item;
    logic              room;
    logic              core_fire;
    result_t           result;
    scan_stat_t        stat;
    logic [MASK_W-1:0] present_mask;

    assign pready    = 1'b1;
    assign core_fire = item_valid && room;

    mtkc_in_buf u_in_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .char_byte  (char_byte),
        .item_valid (item_valid),
        .item       (item),
        .pop        (core_fire)
    );

    mtkc_scan u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (core_fire),
        .item         (item),
        .present_mask (present_mask),
        .result       (result),
        .stat         (stat)
    );

    mtkc_out_reg u_out_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (core_fire),
        .result      (result),
        .room        (room),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .last_device (last_device)
    );

    mtkc_regs u_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .present_mask (present_mask)
    );

`ifndef SYNTHESIS
    // a waiting result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !core_fire)
        else $error("result register overwritten while stalled");

    // a final verdict never changes
    assert property (@(posedge clk) disable iff (!rst_n)
        stat.verdict != ST_RUN |=> stat.verdict == $past(stat.verdict))
        else $error("verdict changed after it was settled");

    // an accept only happens between records
    assert property (@(posedge clk) disable iff (!rst_n)
        core_fire && stat.verdict == ST_RUN && result.status == ST_ACCEPT
        |-> stat.phase == PH_OPEN)
        else $error("accepted inside a record");

    // a delivered status is always a defined code
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != 2'd3)
        else $error("undefined status code");
`endif

endmodule
